### sv/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types, constants and helpers for the barometric compensation block.
// ----------------------------------------------------------------------------
package bsc_pkg;

    typedef enum logic [2:0] {
        CAL_AC1_AC2 = 3'd0,
        CAL_AC3_AC4 = 3'd1,
        CAL_AC5_AC6 = 3'd2,
        CAL_B1_B2   = 3'd3,
        CAL_MC_MD   = 3'd4
    } cal_idx_t;

    typedef struct packed {
        logic [31:0] ac1_ac2;
        logic [31:0] ac3_ac4;
        logic [31:0] ac5_ac6;
        logic [31:0] b1_b2;
        logic [31:0] mc_md;
    } cal_t;

    localparam int TDIV_NUM_W = 27;
    localparam int TDIV_DEN_W = 20;
    localparam int PDIV_NUM_W = 32;
    localparam int PDIV_DEN_W = 17;

    localparam logic [31:0] B6_OFFSET = 32'd4000;
    localparam logic [31:0] K_X1      = 32'd3038;
    localparam logic [31:0] K_X2      = 32'hFFFF_E343; // -7357
    localparam logic [31:0] K_P       = 32'd3791;
    localparam logic [15:0] K_B7      = 16'd50000;
    localparam logic [31:0] K_B4      = 32'd32768;

    // payload riding along the temperature divider
    typedef struct packed {
        logic signed [18:0] t1;
        logic               qneg;
        logic               fault;
        logic [18:0]        up;
        logic [1:0]         mode;
    } tdiv_tag_t;

    // payload riding along the pressure divider
    typedef struct packed {
        logic signed [27:0] temp;
        logic               fault;
        logic               b7_hi;
    } pdiv_tag_t;

    function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] n);
        logic signed [31:0] xs;
        xs = signed'(x);
        return 32'(xs >>> n);
    endfunction

    function automatic logic [31:0] sx32(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

### sv/bsc_div.sv
// ----------------------------------------------------------------------------
// bsc_div
// Pipelined restoring unsigned divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bsc_div #(
    parameter int NUM_W = 27,
    parameter int DEN_W = 20,
    parameter int TAG_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [NUM_W-1:0] quot,
    output logic [TAG_W-1:0] out_tag
);

    logic             v_reg   [NUM_W];
    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0] nq_reg  [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];
    logic [TAG_W-1:0] tag_reg [NUM_W];

    for (genvar i = 0; i < NUM_W; i++)
    begin : g_stage
        logic             v_in;
        logic [DEN_W-1:0] rem_in;
        logic [NUM_W-1:0] nq_in;
        logic [DEN_W-1:0] den_in;
        logic [TAG_W-1:0] tag_in;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;

        if (i == 0)
        begin : g_first
            assign v_in   = in_valid;
            assign rem_in = '0;
            assign nq_in  = num;
            assign den_in = den;
            assign tag_in = in_tag;
        end
        else
        begin : g_next
            assign v_in   = v_reg[i-1];
            assign rem_in = rem_reg[i-1];
            assign nq_in  = nq_reg[i-1];
            assign den_in = den_reg[i-1];
            assign tag_in = tag_reg[i-1];
        end

        assign trial = {rem_in, nq_in[NUM_W-1]};
        assign diff  = trial - {1'b0, den_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else
                v_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (!diff[DEN_W])
            begin
                rem_reg[i] <= diff[DEN_W-1:0];
                nq_reg[i]  <= {nq_in[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg[i] <= trial[DEN_W-1:0];
                nq_reg[i]  <= {nq_in[NUM_W-2:0], 1'b0};
            end
            den_reg[i] <= den_in;
            tag_reg[i] <= tag_in;
        end
    end

    assign out_valid = v_reg[NUM_W-1];
    assign quot      = nq_reg[NUM_W-1];
    assign out_tag   = tag_reg[NUM_W-1];

endmodule

### sv/bsc_temp.sv
// ----------------------------------------------------------------------------
// bsc_temp
// Temperature path: raw product, signed divide, B5 and rounded temperature.
// ----------------------------------------------------------------------------
module bsc_temp (
    input  logic                clk,
    input  logic                rst_n,
    input  bsc_pkg::cal_t       cal,
    input  logic                in_valid,
    input  logic [15:0]         ut,
    input  logic [18:0]         up,
    input  logic [1:0]          mode,
    output logic                out_valid,
    output logic signed [27:0]  b5,
    output logic signed [27:0]  temp,
    output logic                fault,
    output logic [18:0]         up_o,
    output logic [1:0]          mode_o
);

    logic                v1_reg;
    logic signed [33:0]  prod_reg;
    logic [18:0]         up1_reg;
    logic [1:0]          mode1_reg;

    logic signed [16:0]  diff;
    logic signed [16:0]  ac5_s;
    logic signed [33:0]  prod_next;

    assign diff      = signed'({1'b0, ut}) - signed'({1'b0, cal.ac5_ac6[15:0]});
    assign ac5_s     = signed'({1'b0, cal.ac5_ac6[31:16]});
    assign prod_next = diff * ac5_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        up1_reg   <= up;
        mode1_reg <= mode;
    end

    logic signed [18:0]  t1;
    logic signed [15:0]  md;
    logic signed [19:0]  den;
    logic signed [26:0]  num;
    logic [26:0]         num_mag;
    logic [19:0]         den_mag;
    bsc_pkg::tdiv_tag_t  tag_in;
    bsc_pkg::tdiv_tag_t  tag_out;
    logic                dv;
    logic [26:0]         qmag;

    assign t1      = prod_reg[33:15];
    assign md      = signed'(cal.mc_md[15:0]);
    assign den     = 20'(t1) + 20'(md);
    assign num     = signed'({cal.mc_md[31:16], 11'b0});
    assign num_mag = num[26] ? 27'(-num) : 27'(num);
    assign den_mag = den[19] ? 20'(-den) : 20'(den);

    always_comb
    begin
        tag_in.t1    = t1;
        tag_in.qneg  = num[26] ^ den[19];
        tag_in.fault = (den == '0);
        tag_in.up    = up1_reg;
        tag_in.mode  = mode1_reg;
    end

    bsc_div #(
        .NUM_W (bsc_pkg::TDIV_NUM_W),
        .DEN_W (bsc_pkg::TDIV_DEN_W),
        .TAG_W ($bits(bsc_pkg::tdiv_tag_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1_reg),
        .num       (num_mag),
        .den       (den_mag),
        .in_tag    (tag_in),
        .out_valid (dv),
        .quot      (qmag),
        .out_tag   (tag_out)
    );

    logic signed [27:0]  q;
    logic signed [27:0]  b5_next;
    logic signed [27:0]  rnd;

    assign q       = tag_out.qneg ? -signed'({1'b0, qmag}) : signed'({1'b0, qmag});
    assign b5_next = 28'(tag_out.t1) + q;
    assign rnd     = b5_next + 28'sd8;

    logic                v3_reg;
    logic signed [27:0]  b5_reg;
    logic signed [27:0]  temp_reg;
    logic                fault_reg;
    logic [18:0]         up3_reg;
    logic [1:0]          mode3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= dv;
    end

    always_ff @(posedge clk)
    begin
        b5_reg    <= b5_next;
        temp_reg  <= rnd >>> 4;
        fault_reg <= tag_out.fault;
        up3_reg   <= tag_out.up;
        mode3_reg <= tag_out.mode;
    end

    assign out_valid = v3_reg;
    assign b5        = b5_reg;
    assign temp      = temp_reg;
    assign fault     = fault_reg;
    assign up_o      = up3_reg;
    assign mode_o    = mode3_reg;

endmodule

### sv/bsc_press.sv
// ----------------------------------------------------------------------------
// bsc_press
// Pressure path: B6..B7 products, unsigned divide, final correction.
// ----------------------------------------------------------------------------
module bsc_press (
    input  logic                clk,
    input  logic                rst_n,
    input  bsc_pkg::cal_t       cal,
    input  logic                in_valid,
    input  logic signed [27:0]  b5,
    input  logic signed [27:0]  temp,
    input  logic                fault,
    input  logic [18:0]         up,
    input  logic [1:0]          mode,
    output logic                out_valid,
    output logic signed [27:0]  temp_o,
    output logic signed [31:0]  press_o,
    output logic                fault_o
);

    logic [31:0] ac1, ac2, ac3, ac4, b1, b2;

    assign ac1 = bsc_pkg::sx32(cal.ac1_ac2[31:16]);
    assign ac2 = bsc_pkg::sx32(cal.ac1_ac2[15:0]);
    assign ac3 = bsc_pkg::sx32(cal.ac3_ac4[31:16]);
    assign ac4 = {16'b0, cal.ac3_ac4[15:0]};
    assign b1  = bsc_pkg::sx32(cal.b1_b2[31:16]);
    assign b2  = bsc_pkg::sx32(cal.b1_b2[15:0]);

    logic [6:1]          v_reg;
    logic signed [27:0]  temp_reg  [6:1];
    logic                fault_reg [5:1];
    logic [18:0]         up_reg    [5:1];
    logic [1:0]          mode_reg  [5:1];

    logic [31:0] b6_reg;
    logic [31:0] msq_reg, mac2_reg, mac3_reg;
    logic [31:0] mb2_reg, mb1_reg, x2a_reg, x1b_reg;
    logic [31:0] b3pre_reg, x3b_reg;
    logic [31:0] b3_reg, mb4_reg;
    logic [31:0] b7_reg;
    logic [16:0] b4_reg;
    logic        fault6_reg;

    logic [31:0] sq;
    logic [31:0] x3a;
    logic [31:0] b3pre_next;
    logic [31:0] x3b_next;
    logic [31:0] b3_next;
    logic [31:0] b4_full;
    logic [31:0] b7_next;

    assign sq         = bsc_pkg::asr32(msq_reg, 5'd12);
    assign x3a        = bsc_pkg::asr32(mb2_reg, 5'd11) + x2a_reg;
    assign b3pre_next = (((ac1 << 2) + x3a) << mode_reg[3]) + 32'd2;
    assign x3b_next   = bsc_pkg::asr32(bsc_pkg::asr32(mb1_reg, 5'd16) + x1b_reg + 32'd2,
                                       5'd2);
    assign b3_next    = b3pre_reg[31] ? bsc_pkg::asr32(b3pre_reg + 32'd3, 5'd2)
                                      : (b3pre_reg >> 2);
    assign b4_full    = mb4_reg >> 15;
    assign b7_next    = ({13'b0, up_reg[5]} - b3_reg) * {16'b0, bsc_pkg::K_B7 >> mode_reg[5]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[5:1], in_valid};
    end

    always_ff @(posedge clk)
    begin
        temp_reg[1]  <= temp;
        fault_reg[1] <= fault;
        up_reg[1]    <= up;
        mode_reg[1]  <= mode;
        for (int i = 2; i <= 6; i++)
            temp_reg[i] <= temp_reg[i-1];
        for (int i = 2; i <= 5; i++)
        begin
            fault_reg[i] <= fault_reg[i-1];
            up_reg[i]    <= up_reg[i-1];
            mode_reg[i]  <= mode_reg[i-1];
        end

        b6_reg     <= {{4{b5[27]}}, b5} - bsc_pkg::B6_OFFSET;

        msq_reg    <= b6_reg * b6_reg;
        mac2_reg   <= ac2 * b6_reg;
        mac3_reg   <= ac3 * b6_reg;

        mb2_reg    <= b2 * sq;
        mb1_reg    <= b1 * sq;
        x2a_reg    <= bsc_pkg::asr32(mac2_reg, 5'd11);
        x1b_reg    <= bsc_pkg::asr32(mac3_reg, 5'd13);

        b3pre_reg  <= b3pre_next;
        x3b_reg    <= x3b_next;

        b3_reg     <= b3_next;
        mb4_reg    <= ac4 * (x3b_reg + bsc_pkg::K_B4);

        b4_reg     <= b4_full[16:0];
        b7_reg     <= b7_next;
        fault6_reg <= fault_reg[5] | (b4_full == '0);
    end

    logic [31:0]          dnum;
    bsc_pkg::pdiv_tag_t   dtag_in;
    bsc_pkg::pdiv_tag_t   dtag_out;
    logic                 dv;
    logic [31:0]          dq;

    assign dnum = b7_reg[31] ? b7_reg : {b7_reg[30:0], 1'b0};

    always_comb
    begin
        dtag_in.temp  = temp_reg[6];
        dtag_in.fault = fault6_reg;
        dtag_in.b7_hi = b7_reg[31];
    end

    bsc_div #(
        .NUM_W (bsc_pkg::PDIV_NUM_W),
        .DEN_W (bsc_pkg::PDIV_DEN_W),
        .TAG_W ($bits(bsc_pkg::pdiv_tag_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_reg[6]),
        .num       (dnum),
        .den       (b4_reg),
        .in_tag    (dtag_in),
        .out_valid (dv),
        .quot      (dq),
        .out_tag   (dtag_out)
    );

    logic [31:0] q;
    logic [31:0] qa;

    assign q  = dtag_out.b7_hi ? {dq[30:0], 1'b0} : dq;
    assign qa = bsc_pkg::asr32(q, 5'd8);

    logic [3:1]          w_reg;
    bsc_pkg::pdiv_tag_t  t8_reg, t9_reg;
    logic [31:0]         p8_reg, m1_reg, m2_reg;
    logic [31:0]         p9_reg, m3_reg, x2_reg;
    logic signed [27:0]  temp_out_reg;
    logic signed [31:0]  press_out_reg;
    logic                fault_out_reg;

    logic [31:0] x1;
    logic [31:0] p_final;

    assign x1      = bsc_pkg::asr32(m3_reg, 5'd16);
    assign p_final = p9_reg + bsc_pkg::asr32(x1 + x2_reg + bsc_pkg::K_P, 5'd4);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            w_reg <= '0;
        else
            w_reg <= {w_reg[2:1], dv};
    end

    always_ff @(posedge clk)
    begin
        t8_reg <= dtag_out;
        p8_reg <= q;
        m1_reg <= qa * qa;
        m2_reg <= bsc_pkg::K_X2 * q;

        t9_reg <= t8_reg;
        p9_reg <= p8_reg;
        m3_reg <= m1_reg * bsc_pkg::K_X1;
        x2_reg <= bsc_pkg::asr32(m2_reg, 5'd16);

        temp_out_reg  <= t9_reg.fault ? '0 : t9_reg.temp;
        press_out_reg <= t9_reg.fault ? '0 : signed'(p_final);
        fault_out_reg <= t9_reg.fault;
    end

    assign out_valid = w_reg[3];
    assign temp_o    = temp_out_reg;
    assign press_o   = press_out_reg;
    assign fault_o   = fault_out_reg;

endmodule

### sv/barometric_sensor_compensation.sv
// ----------------------------------------------------------------------------
// barometric_sensor_compensation
// Fixed-point temperature and pressure compensation, fully pipelined.
// ----------------------------------------------------------------------------
// One request is taken per clock whenever start is high; busy never rises.
// Each result appears on done exactly 71 cycles after the accepting edge,
// in request order, and must be captured in that cycle. The latency is set
// by two bit-serial pipelined dividers (27 and 32 stages) plus the multiply
// stages around them. Calibration writes are taken at any time through the
// cfg channel and must only be issued while no request is in flight.
module barometric_sensor_compensation (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [15:0]         raw_temp,
    input  logic [18:0]         raw_press,
    input  logic [1:0]          oversample,
    output logic                done,
    output logic signed [27:0]  temp_tenths,
    output logic signed [31:0]  press_pa,
    output logic                div_fault,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    localparam int LATENCY = 71;

    bsc_pkg::cal_t  cal_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cal_reg <= '0;
        else if (cfg_valid && cfg_ready)
        begin
            unique case (bsc_pkg::cal_idx_t'(cfg_index))
                bsc_pkg::CAL_AC1_AC2: cal_reg.ac1_ac2 <= cfg_data;
                bsc_pkg::CAL_AC3_AC4: cal_reg.ac3_ac4 <= cfg_data;
                bsc_pkg::CAL_AC5_AC6: cal_reg.ac5_ac6 <= cfg_data;
                bsc_pkg::CAL_B1_B2:   cal_reg.b1_b2   <= cfg_data;
                bsc_pkg::CAL_MC_MD:   cal_reg.mc_md   <= cfg_data;
                default:              cal_reg         <= cal_reg;
            endcase
        end
    end

    logic        v0_reg;
    logic [15:0] ut0_reg;
    logic [18:0] up0_reg;
    logic [1:0]  mode0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        ut0_reg   <= raw_temp;
        up0_reg   <= raw_press;
        mode0_reg <= oversample;
    end

    logic                tv;
    logic signed [27:0]  tb5;
    logic signed [27:0]  ttemp;
    logic                tfault;
    logic [18:0]         tup;
    logic [1:0]          tmode;

    bsc_temp u_temp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cal       (cal_reg),
        .in_valid  (v0_reg),
        .ut        (ut0_reg),
        .up        (up0_reg),
        .mode      (mode0_reg),
        .out_valid (tv),
        .b5        (tb5),
        .temp      (ttemp),
        .fault     (tfault),
        .up_o      (tup),
        .mode_o    (tmode)
    );

    bsc_press u_press (
        .clk       (clk),
        .rst_n     (rst_n),
        .cal       (cal_reg),
        .in_valid  (tv),
        .b5        (tb5),
        .temp      (ttemp),
        .fault     (tfault),
        .up        (tup),
        .mode      (tmode),
        .out_valid (done),
        .temp_o    (temp_tenths),
        .press_o   (press_pa),
        .fault_o   (div_fault)
    );

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && div_fault |-> temp_tenths == '0 && press_pa == '0)
        else $error("fault result not zeroed");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("result missing at expected latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without matching request");

endmodule

### tb/sv/tb_barometric_sensor_compensation.sv
// ----------------------------------------------------------------------------
// tb_barometric_sensor_compensation
// Drives conversion requests and calibration writes into the compensation
// block, predicts temperature, pressure and fault for each request, and
// compares every strobed result in order against the prediction.
// ----------------------------------------------------------------------------
class comp_scoreboard;
    logic [27:0] exp_temp [$];
    logic [31:0] exp_press [$];
    logic        exp_fault [$];
    logic [31:0] cal [5];
    int          errors;

    function new();
        errors = 0;
        foreach (cal[i]) cal[i] = '0;
    endfunction

    function void set_cal(int idx, logic [31:0] v);
        if (idx < 5) cal[idx] = v;
    endfunction

    function automatic logic [31:0] shr_s(logic [31:0] x, int n);
        logic signed [31:0] xs;
        xs = x;
        return xs >>> n;
    endfunction

    function void note_request(logic [15:0] ut, logic [18:0] up, logic [1:0] mode);
        longint ac5, ac6, mc, md, prod, t1, den, b5, tv;
        logic [31:0] ac1, ac2, ac3, b1, b2, ac4;
        logic [31:0] b6, sq, x1, x2, x3, b3, b4, b7, q, p;
        logic signed [31:0] b3s;
        ac1 = {{16{cal[0][31]}}, cal[0][31:16]};
        ac2 = {{16{cal[0][15]}}, cal[0][15:0]};
        ac3 = {{16{cal[1][31]}}, cal[1][31:16]};
        ac4 = {16'd0, cal[1][15:0]};
        ac5 = cal[2][31:16];
        ac6 = cal[2][15:0];
        b1  = {{16{cal[3][31]}}, cal[3][31:16]};
        b2  = {{16{cal[3][15]}}, cal[3][15:0]};
        mc  = longint'($signed(cal[4][31:16]));
        md  = longint'($signed(cal[4][15:0]));
        prod = (longint'(ut) - ac6) * ac5;
        t1 = prod >>> 15;
        den = t1 + md;
        if (den == 0)
        begin
            exp_temp.push_back('0); exp_press.push_back('0); exp_fault.push_back(1'b1);
            return;
        end
        b5 = t1 + (mc * 2048) / den;
        tv = (b5 + 8) >>> 4;
        b6 = 32'(b5 - 4000);
        sq = shr_s(b6 * b6, 12);
        x1 = shr_s(b2 * sq, 11);
        x2 = shr_s(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = ((ac1 * 32'd4 + x3) << mode) + 32'd2;
        b3s = b3;
        b3s = b3s / 4;
        b3 = b3s;
        x1 = shr_s(ac3 * b6, 13);
        x2 = shr_s(b1 * sq, 16);
        x3 = shr_s(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + 32'd32768)) >> 15;
        b7 = ({13'd0, up} - b3) * (32'd50000 >> mode);
        if (b4 == 0)
        begin
            exp_temp.push_back('0); exp_press.push_back('0); exp_fault.push_back(1'b1);
            return;
        end
        if (b7 < 32'h8000_0000) q = (b7 * 32'd2) / b4;
        else q = (b7 / b4) * 32'd2;
        p = q;
        x1 = shr_s(p, 8) * shr_s(p, 8);
        x1 = shr_s(x1 * 32'd3038, 16);
        x2 = shr_s(32'hFFFF_E343 * p, 16);
        p = p + shr_s(x1 + x2 + 32'd3791, 4);
        exp_temp.push_back(28'(tv));
        exp_press.push_back(p);
        exp_fault.push_back(1'b0);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    task check_result(logic [27:0] t, logic [31:0] p, logic f);
        logic [27:0] et;
        logic [31:0] ep;
        logic        ef;
        if (exp_temp.size() == 0)
        begin
            report("unexpected result", {4'd0, t}, 32'd0);
            return;
        end
        et = exp_temp.pop_front();
        ep = exp_press.pop_front();
        ef = exp_fault.pop_front();
        if (t !== et) report("temp_tenths", {4'd0, t}, {4'd0, et});
        if (p !== ep) report("press_pa", p, ep);
        if (f !== ef) report("div_fault", {31'd0, f}, {31'd0, ef});
    endtask

    function int pending();
        return exp_temp.size();
    endfunction
endclass

module tb_barometric_sensor_compensation;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 71;
    localparam longint CYCLE_LIMIT = 400000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [15:0]        raw_temp;
    logic [18:0]        raw_press;
    logic [1:0]         oversample;
    logic               done;
    logic signed [27:0] temp_tenths;
    logic signed [31:0] press_pa;
    logic               div_fault;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    comp_scoreboard sb;
    int idle_pct;
    longint cycles;

    barometric_sensor_compensation u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .raw_temp(raw_temp), .raw_press(raw_press), .oversample(oversample),
        .done(done), .temp_tenths(temp_tenths), .press_pa(press_pa),
        .div_fault(div_fault), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout");
                $display("tb_barometric_sensor_compensation NOT OK");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(temp_tenths, press_pa, div_fault);
    end

    task automatic write_cal(bsc_pkg::cal_idx_t idx, logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        sb.set_cal(int'(idx), v);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending() != 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic send_request(logic [15:0] ut, logic [18:0] up, logic [1:0] m);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        raw_temp   <= ut;
        raw_press  <= up;
        oversample <= m;
        do @(posedge clk); while (busy);
        sb.note_request(ut, up, m);
    endtask

    task automatic end_burst();
        start <= 1'b0;
        @(posedge clk);
    endtask

    // typical sensor calibration with some jitter, or fully random words
    task automatic load_cal(bit typical);
        if (typical)
        begin
            write_cal(bsc_pkg::CAL_AC1_AC2, {16'(408 + $urandom_range(200) - 100),
                                             16'(-72 + $urandom_range(40) - 20)});
            write_cal(bsc_pkg::CAL_AC3_AC4, {16'(-14383 + $urandom_range(2000) - 1000),
                                             16'(32741 + $urandom_range(2000) - 1000)});
            write_cal(bsc_pkg::CAL_AC5_AC6, {16'(32757 - $urandom_range(2000)),
                                             16'(23153 + $urandom_range(2000) - 1000)});
            write_cal(bsc_pkg::CAL_B1_B2, {16'(6190 + $urandom_range(200) - 100),
                                           16'(4 + $urandom_range(8))});
            write_cal(bsc_pkg::CAL_MC_MD, {16'(-8711 + $urandom_range(400) - 200),
                                           16'(2868 + $urandom_range(400) - 200)});
        end
        else
        begin
            write_cal(bsc_pkg::CAL_AC1_AC2, $urandom);
            write_cal(bsc_pkg::CAL_AC3_AC4, $urandom);
            write_cal(bsc_pkg::CAL_AC5_AC6, $urandom);
            write_cal(bsc_pkg::CAL_B1_B2, $urandom);
            write_cal(bsc_pkg::CAL_MC_MD, $urandom);
        end
    endtask

    task automatic random_burst(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(3) != 0)
                send_request(16'(27898 + $urandom_range(8000) - 4000),
                             19'($urandom_range(20000, 30000) << $urandom_range(3)),
                             2'($urandom_range(3)));
            else
                send_request(16'($urandom), 19'($urandom), 2'($urandom));
        end
        end_burst();
    endtask

    initial
    begin
        sb = new();
        idle_pct   = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        raw_temp   = '0;
        raw_press  = '0;
        oversample = '0;
        cfg_valid  = 1'b0;
        cfg_index  = bsc_pkg::CAL_AC1_AC2;
        cfg_data   = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all-zero calibration: temperature divisor is zero
        send_request(16'hFFFF, 19'h7FFFF, 2'd3);
        end_burst();
        drain();

        write_cal(bsc_pkg::CAL_AC1_AC2, {16'd408, 16'hFFB8});
        write_cal(bsc_pkg::CAL_AC3_AC4, {16'hC7D1, 16'd32741});
        write_cal(bsc_pkg::CAL_AC5_AC6, {16'd32757, 16'd23153});
        write_cal(bsc_pkg::CAL_B1_B2, {16'd6190, 16'd4});
        write_cal(bsc_pkg::CAL_MC_MD, {16'hDDF9, 16'd2868});
        send_request(16'd27898, 19'd23843, 2'd0);
        send_request(16'd0, 19'd0, 2'd0);
        send_request(16'hFFFF, 19'h7FFFF, 2'd3);
        send_request(16'h8000, 19'h40000, 2'd1);
        send_request(16'd27898, 19'd95372, 2'd2);
        send_request(16'd27898, 19'h55555, 2'd3);
        send_request(16'h5555, 19'h2AAAA, 2'd1);
        send_request(16'hAAAA, 19'h55555, 2'd2);
        end_burst();
        drain();

        // ac4 zero: pressure divisor is zero
        write_cal(bsc_pkg::CAL_AC3_AC4, {16'hC7D1, 16'd0});
        send_request(16'd27898, 19'd23843, 2'd0);
        end_burst();
        drain();

        // extreme calibration words
        write_cal(bsc_pkg::CAL_AC1_AC2, 32'h7FFF_8000);
        write_cal(bsc_pkg::CAL_AC3_AC4, 32'h8000_FFFF);
        write_cal(bsc_pkg::CAL_AC5_AC6, 32'hFFFF_FFFF);
        write_cal(bsc_pkg::CAL_B1_B2, 32'h7FFF_8000);
        write_cal(bsc_pkg::CAL_MC_MD, 32'h8000_0001);
        send_request(16'hFFFF, 19'd0, 2'd0);
        send_request(16'hFFFE, 19'h7FFFF, 2'd3);
        send_request(16'd0, 19'h7FFFF, 2'd0);
        end_burst();
        drain();
        write_cal(bsc_pkg::CAL_MC_MD, 32'h7FFF_7FFF);
        send_request(16'd0, 19'd0, 2'd3);
        send_request(16'hFFFF, 19'h7FFFF, 2'd1);
        end_burst();
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct = (ph == 0) ? 12 : (ph == 1) ? 56 : 0;
            for (int k = 0; k < 4; k++)
            begin
                load_cal(k != 3);
                random_burst(95);
                drain();
            end
        end

        if (sb.errors == 0)
            $display("tb_barometric_sensor_compensation OK");
        else
            $display("tb_barometric_sensor_compensation NOT OK");
        $finish;
    end
endmodule
